/* rtl/f2h_pkg.sv */
// Shared types and constants for the single- to half-precision float converter.
package f2h_pkg;

   localparam int FLOAT_W = 32;
   localparam int HALF_W  = 16;

   typedef logic [FLOAT_W-1:0] float_type;
   typedef logic [HALF_W-1:0]  half_type;

   typedef struct packed {
      half_type half_bits;
      logic     overflow_flag;
   } result_type;

   // Half infinity magnitude, exponent all ones
   localparam logic [14:0] HALF_INF      = 15'h7c00;
   // Rounding increment below the kept fraction bits
   localparam logic [23:0] RND_BELOW     = 24'h000fff;
   localparam logic [23:0] HIDDEN_BIT    = 24'h800000;
   // Float exponent bias minus half exponent bias (127 - 15)
   localparam logic [7:0]  EXP_REBIAS    = 8'd112;
   // Subnormal shift is 14 - e = 126 - biased exponent
   localparam logic [7:0]  SUB_SHIFT_TOP = 8'd126;

   localparam logic [7:0]  EXP_SUB_LO    = 8'd102;
   localparam logic [7:0]  EXP_SUB_HI    = 8'd112;
   localparam logic [7:0]  EXP_NORM_LO   = 8'd113;
   localparam logic [7:0]  EXP_NORM_HI   = 8'd141;
   localparam logic [7:0]  EXP_TOP       = 8'd142;
   localparam logic [7:0]  EXP_BIG_HI    = 8'd254;
   localparam logic [7:0]  EXP_SPECIAL   = 8'd255;
   localparam logic [4:0]  HALF_EXP_TOP  = 5'd30;

endpackage

/* rtl/f2h_if.sv */
// Valid/ready channel interfaces for float words in and half words out.
interface f2h_req_if;
   import f2h_pkg::*;

   logic      valid;
   logic      ready;
   float_type float_bits;

   modport source (output valid, output float_bits, input ready);
   modport sink   (input valid, input float_bits, output ready);
endinterface

interface f2h_rsp_if;
   import f2h_pkg::*;

   logic     valid;
   logic     ready;
   half_type half_bits;
   logic     overflow_flag;

   modport source (output valid, output half_bits, output overflow_flag, input ready);
   modport sink   (input valid, input half_bits, input overflow_flag, output ready);
endinterface

/* rtl/f2h_conv.sv */
// Combinational binary32 to binary16 conversion with rounding and overflow detect.
module f2h_conv (
   input  f2h_pkg::float_type  float_bits,
   output f2h_pkg::result_type result
);
   import f2h_pkg::*;

   logic        sign;
   logic [7:0]  bexp;
   logic [22:0] frac;
   logic [7:0]  e_full;
   logic [10:0] norm_m;
   logic [14:0] norm_mag;
   logic [7:0]  t_full;
   logic [4:0]  t;
   logic [24:0] sig;
   logic [24:0] sub_a;
   logic        sub_b;
   logic [24:0] sub_sum;
   logic [24:0] sub_shifted;
   logic [23:0] top_sum;
   logic [9:0]  nan_m;
   logic [14:0] mag;
   logic        ovf;

   assign sign   = float_bits[31];
   assign bexp   = float_bits[30:23];
   assign frac   = float_bits[22:0];

   // Plain normal: round on fraction bit 12, ties away from zero
   assign e_full   = bexp - EXP_REBIAS;
   assign norm_m   = {1'b0, frac[22:13]} + {10'b0, frac[12]};
   assign norm_mag = {e_full[4:0], 10'b0} + {4'b0, norm_m};

   // Half subnormal: shift significand right by t, ties to even
   assign t_full      = SUB_SHIFT_TOP - bexp;
   assign t           = t_full[4:0];
   assign sig         = {1'b0, HIDDEN_BIT | {1'b0, frac}};
   assign sub_a       = (25'd1 << (t - 5'd1)) - 25'd1;
   assign sub_b       = sig[t];
   assign sub_sum     = sig + sub_a + {24'b0, sub_b};
   assign sub_shifted = sub_sum >> t;

   // Top exponent: ties to even, carry into the hidden bit overflows
   assign top_sum = {1'b0, frac} + RND_BELOW + {23'b0, frac[13]};

   assign nan_m = frac[22:13];

   always_comb begin
      mag = 15'b0;
      ovf = 1'b0;
      case (bexp) inside
         [EXP_SUB_LO:EXP_SUB_HI]: begin
            mag = sub_shifted[14:0];
         end
         [EXP_NORM_LO:EXP_NORM_HI]: begin
            mag = norm_mag;
         end
         [EXP_TOP:EXP_BIG_HI]: begin
            if (bexp == EXP_TOP && !top_sum[23]) begin
               mag = {HALF_EXP_TOP, top_sum[22:13]};
            end else begin
               mag = HALF_INF;
               ovf = 1'b1;
            end
         end
         EXP_SPECIAL: begin
            if (frac == 23'b0) begin
               mag = HALF_INF;
            end else begin
               // keep NaN a NaN when the top fraction bits are all zero
               mag = HALF_INF | {5'b0, nan_m | {9'b0, nan_m == 10'b0}};
            end
         end
         default: begin
            mag = 15'b0;
         end
      endcase
   end

   assign result.half_bits     = {sign, mag};
   assign result.overflow_flag = ovf;

endmodule

/* rtl/float32_to_float16.sv */
// An accepted word goes through input register, conversion logic, output register.
// Throughput: one word per cycle while the response side does not stall.
// The input stage takes one more word while a finished response waits to be taken.
// Backpressure stalls both stages; req ready depends on rsp ready and stage occupancy.
// Reset (synchronous, active high) empties both stages; payload registers are not reset.
module float32_to_float16 (
   input logic      clock,
   input logic      reset,
   f2h_req_if.sink   req_chan,
   f2h_rsp_if.source rsp_chan
);
   import f2h_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   float_type  in_bits_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;
   result_type conv_res;
   logic       out_load;
   logic       in_load;

   f2h_conv u_conv (
      .float_bits (in_bits_ff),
      .result     (conv_res)
   );

   // Output stage takes a new word when empty or being drained
   assign out_load = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || out_load;
   assign in_load = req_chan.valid && req_chan.ready;

   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_bits_ff <= req_chan.float_bits;
      end
      if (out_load && in_valid_ff) begin
         out_res_ff <= conv_res;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.half_bits     = out_res_ff.half_bits;
   assign rsp_chan.overflow_flag = out_res_ff.overflow_flag;

   // A word in the input stage moves on whenever the output stage loads
   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_load |=> out_valid_ff)
      else $error("input stage word not advanced to output stage");

   // A blocked input-stage word holds its bits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_load |=> in_valid_ff && $stable(in_bits_ff))
      else $error("blocked input stage word lost or changed");

   // Overflow only ever comes with a signed infinity
   a_ovf_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.overflow_flag |-> rsp_chan.half_bits[14:0] == HALF_INF)
      else $error("overflow flag without infinity");

endmodule

/* verif/float32_to_float16_tb.sv */
// Self-checking testbench for the single- to half-precision float converter.
module float32_to_float16_tb;
   import f2h_pkg::*;

   localparam int NUM_RANDOM   = 850;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_LIMIT  = 5000;

   // Edge cases: signed zeros, tiny values, half subnormal ties and carries,
   // both rounding modes, mantissa carries, overflow, infinity and NaN
   localparam float_type DIRECTED_WORDS [0:24] = '{
      32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807f_ffff, 32'h32ff_ffff,
      32'h3300_0000, 32'h3300_0001, 32'hb340_0000, 32'h3800_2000, 32'h3800_6000,
      32'h387f_ffff, 32'h3f80_0000, 32'hbf80_1000, 32'h3f80_0fff, 32'h3880_0000,
      32'h46ff_ffff, 32'h477f_e000, 32'h477f_d000, 32'h477f_f000, 32'hc780_0000,
      32'h7f7f_ffff, 32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'hff80_0001
   };

   typedef struct {
      float_type  float_bits;
      result_type half_res;
   } half_expect_type;

   class half_scoreboard;
      half_expect_type waiting[$];
      int errors;
      int checked;
      int overflows;

      // Rebias the exponent and round the fraction per exponent range
      function result_type float_to_half(float_type f);
         logic        sgn;
         logic [7:0]  bexp;
         logic [31:0] frac, sig, a, b, m;
         int          e, t;
         result_type  r;
         sgn  = f[31];
         bexp = f[30:23];
         frac = {9'b0, f[22:0]};
         e    = int'(bexp) - int'(EXP_REBIAS);
         r.overflow_flag = 1'b0;
         r.half_bits     = {sgn, 15'b0};
         if (bexp == 8'd0 && frac == 32'd0) begin
            return r;
         end
         if (e >= 1 && e <= 29) begin
            // ties away from zero: add the first dropped bit
            m   = (frac >> 13) + ((frac >> 12) & 32'd1);
            sig = (32'(e) << 10) + m;
            r.half_bits[14:0] = sig[14:0];
         end else if (e <= 0) begin
            if (e >= -10) begin
               t   = 14 - e;
               sig = frac | 32'h0080_0000;
               a   = (32'd1 << (t - 1)) - 32'd1;
               b   = (sig >> t) & 32'd1;
               m   = (sig + a + b) >> t;
               r.half_bits[14:0] = m[14:0];
            end
         end else if (bexp == 8'hff) begin
            m = frac >> 13;
            r.half_bits[14:0] = HALF_INF | m[14:0] | 15'(m == 32'd0 && frac != 32'd0);
         end else begin
            frac = frac + {8'b0, RND_BELOW} + ((frac >> 13) & 32'd1);
            if (frac[23]) begin
               frac = 32'd0;
               e    = e + 1;
            end
            if (e > 30) begin
               r.overflow_flag   = 1'b1;
               r.half_bits[14:0] = HALF_INF;
            end else begin
               sig = (32'(e) << 10) | (frac >> 13);
               r.half_bits[14:0] = sig[14:0];
            end
         end
         return r;
      endfunction

      function void note_float(float_type f);
         half_expect_type x;
         x.float_bits = f;
         x.half_res   = float_to_half(f);
         waiting.push_back(x);
      endfunction

      function void check_half(half_type h, logic ovf);
         half_expect_type x;
         if (waiting.size() == 0) begin
            errors++;
            $display("%0t: unexpected half word %h ovf %b", $time, h, ovf);
            return;
         end
         x = waiting.pop_front();
         checked++;
         if (x.half_res.overflow_flag) overflows++;
         if (h !== x.half_res.half_bits || ovf !== x.half_res.overflow_flag) begin
            errors++;
            $display("%0t: float %h expected half %h ovf %b, got half %h ovf %b",
                     $time, x.float_bits, x.half_res.half_bits,
                     x.half_res.overflow_flag, h, ovf);
         end
      endfunction

      function int pending();
         return waiting.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic steady;
   logic hold_off_req;
   half_scoreboard board = new();

   f2h_req_if req_chan();
   f2h_rsp_if rsp_chan();

   float32_to_float16 dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, board.pending());
      $display("FAILURE");
      $finish;
   end

   // Bias toward exponents near the half range and rounding boundaries
   function automatic float_type random_float();
      logic [31:0] frac, mask, low;
      logic [7:0]  bexp;
      int          sel, t;
      sel  = $urandom_range(99);
      frac = $urandom & 32'h007f_ffff;
      if (sel < 30) begin
         return $urandom;
      end
      if (sel < 65) begin
         bexp = 8'($urandom_range(143, 100));
      end else if (sel < 80) begin
         bexp = 8'($urandom_range(143, 139));
         case ($urandom_range(4))
            0: low = 32'h1000;
            1: low = 32'h0fff;
            2: low = 32'h1001;
            3: low = 32'h1fff;
            default: low = 32'h0000;
         endcase
         frac = (frac & ~32'h1fff) | low;
      end else if (sel < 90) begin
         // half subnormal with the dropped bits at or next to a tie
         bexp = 8'($urandom_range(112, 102));
         t    = int'(SUB_SHIFT_TOP) - int'(bexp);
         mask = (32'd1 << t) - 32'd1;
         low  = (32'd1 << (t - 1)) + 32'($urandom_range(2)) - 32'd1;
         frac = ((frac & ~mask) | (low & mask)) & 32'h007f_ffff;
      end else begin
         bexp = $urandom_range(1) ? 8'hff : 8'h00;
         case ($urandom_range(2))
            0: frac = 32'd0;
            1: frac = frac & 32'h1fff;
            default: ;
         endcase
      end
      return {1'($urandom_range(1)), bexp, frac[22:0]};
   endfunction

   task automatic send_word(input float_type f);
      while (!steady && $urandom_range(99) < 10) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.float_bits = f;
      do @(posedge clock); while (!req_chan.ready);
      board.note_float(f);
      @(negedge clock);
   endtask

   // Response side ready: random stalls, plus one long hold-off on request
   initial begin
      int k;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_chan.ready = 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(negedge clock);
            hold_off_req = 1'b0;
         end
         rsp_chan.ready = steady || $urandom_range(99) >= 10;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_half(rsp_chan.half_bits, rsp_chan.overflow_flag);
   end

   initial begin
      int i, n;
      reset               = 1'b1;
      steady              = 1'b0;
      hold_off_req        = 1'b0;
      req_chan.valid      = 1'b0;
      req_chan.float_bits = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_WORDS[j]) send_word(DIRECTED_WORDS[j]);

      for (i = 0; i < NUM_RANDOM; i++) begin
         steady = (i >= 200 && i < 350);
         if (i == 450) hold_off_req = 1'b1;
         if (i == 650) begin
            // hold until the pipeline has fully drained
            req_chan.valid = 1'b0;
            while (board.pending() != 0) @(negedge clock);
         end
         send_word(random_float());
      end
      req_chan.valid = 1'b0;

      n = 0;
      while (board.pending() != 0 && n < DRAIN_LIMIT) begin
         @(negedge clock);
         n++;
      end
      repeat (4) @(negedge clock);
      if (board.pending() != 0)
         $display("%0t: %0d expected results never arrived", $time, board.pending());

      $display("Converted %0d floats (%0d edge cases, %0d random), %0d overflowed to infinity;",
               board.checked, $size(DIRECTED_WORDS), NUM_RANDOM, board.overflows);
      $display("random idling on both sides, one long output stall and one full drain.");
      if (board.errors == 0 && board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/f2h_pkg.sv
rtl/f2h_if.sv
rtl/f2h_conv.sv
rtl/float32_to_float16.sv
verif/float32_to_float16_tb.sv
